### rtl/cnlc_pkg.sv
// Shared widths, digit-count constants and result class codes for the card classifier.
`default_nettype none

package cnlc_pkg;

  // Payload widths
  localparam int CARD_W = 63;
  localparam int CLASS_W = 2;

  // Decimal digits that a 63-bit value can hold, and the packed BCD width
  localparam int NDIG = 19;
  localparam int BCD_W = 4 * NDIG;
  localparam int DIG_IDX_W = $clog2(NDIG);
  localparam int DIG_CNT_W = $clog2(NDIG + 1);
  localparam int BIT_CNT_W = $clog2(CARD_W);

  // Valid card lengths
  localparam logic [DIG_CNT_W-1:0] LEN_VISA_SHORT = DIG_CNT_W'(13);
  localparam logic [DIG_CNT_W-1:0] LEN_AMEX = DIG_CNT_W'(15);
  localparam logic [DIG_CNT_W-1:0] LEN_LONG = DIG_CNT_W'(16);

  // Result class codes
  localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_VISA = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_AMEX = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_MASTERCARD = 2'd3;

endpackage

`default_nettype wire

### rtl/cnlc_ifs.sv
// Valid/ready channel interfaces for card numbers in and class codes out.
`default_nettype none

interface cnlc_in_if;
  logic valid;
  logic ready;
  logic [cnlc_pkg::CARD_W-1:0] card_number;

  modport source (output valid, output card_number, input ready);
  modport sink (input valid, input card_number, output ready);
endinterface

interface cnlc_out_if;
  logic valid;
  logic ready;
  logic [cnlc_pkg::CLASS_W-1:0] card_class;

  modport source (output valid, output card_class, input ready);
  modport sink (input valid, input card_class, output ready);
endinterface

`default_nettype wire

### rtl/cnlc_b2bcd.sv
// Iterative binary to BCD converter: one shift-and-add-3 step per clock.
`default_nettype none

module cnlc_b2bcd (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [cnlc_pkg::CARD_W-1:0] bin,
  output logic                             done,
  output logic [cnlc_pkg::BCD_W-1:0]       bcd
);
  import cnlc_pkg::*;

  logic [CARD_W-1:0]    bin_r;
  logic [BCD_W-1:0]     bcd_r;
  logic [BCD_W-1:0]     adj;
  logic [BIT_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Control: count the input bits through, flag completion
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BIT_CNT_W'(CARD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: load, then shift one binary bit into the BCD word per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= {bin_r[CARD_W-2:0], 1'b0};
      bcd_r <= {adj[BCD_W-2:0], bin_r[CARD_W-1]};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

`default_nettype wire

### rtl/card_number_luhn_classifier.sv
// Card number classifier: BCD conversion, digit scan with Luhn sum, issuer class.
// From input accept to result valid: conversion in the shift-and-add-3 unit (63 steps),
// a handoff, the digit scan (19 steps), then classify. A new card number is taken only
// once the sequencer is idle again, which may be while the previous result still waits in
// the output register; a result that cannot be loaded yet holds the sequencer in ST_DONE.
// Reset: synchronous active-low rst_n empties the output register and idles the sequencer.
`default_nettype none

module card_number_luhn_classifier (
  input  wire logic clk,
  input  wire logic rst_n,
  cnlc_in_if.sink   in_chan,
  cnlc_out_if.source out_chan
);
  import cnlc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 conv_start;
  logic                 conv_done;
  logic [BCD_W-1:0]     conv_bcd;

  logic [BCD_W-1:0]     dig_r;
  logic [DIG_IDX_W-1:0] k_r;
  logic [3:0]           sum_r;
  logic [DIG_CNT_W-1:0] len_r;
  logic [3:0]           lead_hi_r;
  logic [3:0]           lead_lo_r;
  logic [3:0]           prev_r;

  logic                 out_valid_r;
  logic [CLASS_W-1:0]   class_r;

  logic [3:0]           d;
  logic [4:0]           d2;
  logic [3:0]           term;
  logic [4:0]           sum_raw;
  logic [3:0]           sum_nxt;
  logic                 out_free;
  logic                 in_acc;
  logic [CLASS_W-1:0]   class_nxt;

  assign in_acc     = in_chan.valid && in_chan.ready;
  assign conv_start = in_acc;
  assign out_free   = !out_valid_r || out_chan.ready;

  cnlc_b2bcd u_b2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (in_chan.card_number),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // Luhn term of the current digit: double every digit at an odd index from the right
  always_comb begin
    d  = dig_r[3:0];
    d2 = {d, 1'b0};
    if (k_r[0]) begin
      if (d2 > 5'd9) begin
        term = 4'(d2 - 5'd9);
      end else begin
        term = d2[3:0];
      end
    end else begin
      term = d;
    end
    sum_raw = {1'b0, sum_r} + {1'b0, term};
    if (sum_raw >= 5'd10) begin
      sum_nxt = 4'(sum_raw - 5'd10);
    end else begin
      sum_nxt = sum_raw[3:0];
    end
  end

  // Classify by length, Luhn remainder and leading digits
  always_comb begin
    class_nxt = CLASS_INVALID;
    if (sum_r == 4'd0) begin
      if (len_r == LEN_VISA_SHORT) begin
        if (lead_hi_r == 4'd4) class_nxt = CLASS_VISA;
      end else if (len_r == LEN_AMEX) begin
        if (lead_hi_r == 4'd3 && (lead_lo_r == 4'd4 || lead_lo_r == 4'd7)) begin
          class_nxt = CLASS_AMEX;
        end
      end else if (len_r == LEN_LONG) begin
        if (lead_hi_r == 4'd4) begin
          class_nxt = CLASS_VISA;
        end else if (lead_hi_r == 4'd5 && lead_lo_r >= 4'd1 && lead_lo_r <= 4'd5) begin
          class_nxt = CLASS_MASTERCARD;
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CONV;
      ST_CONV: if (conv_done) state_nxt = ST_SCAN;
      ST_SCAN: if (k_r == DIG_IDX_W'(NDIG - 1)) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan the digits from the right, one per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_CONV && conv_done) begin
      dig_r     <= conv_bcd;
      k_r       <= '0;
      sum_r     <= '0;
      len_r     <= '0;
      lead_hi_r <= '0;
      lead_lo_r <= '0;
      prev_r    <= '0;
    end else if (state_r == ST_SCAN) begin
      dig_r  <= {4'd0, dig_r[BCD_W-1:4]};
      k_r    <= k_r + 1'b1;
      sum_r  <= sum_nxt;
      prev_r <= d;
      if (d != 4'd0) begin
        len_r     <= DIG_CNT_W'(k_r) + 1'b1;
        lead_hi_r <= d;
        lead_lo_r <= prev_r;
      end
    end
  end

  // Output register: load on finish, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      class_r <= class_nxt;
    end
  end

  assign in_chan.ready       = (state_r == ST_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.card_class = class_r;

endmodule

`default_nettype wire

### rtl/cnlc_checker.sv
// Port-level assertions for the card classifier and the bind that attaches them.
`default_nettype none

module cnlc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [cnlc_pkg::CLASS_W-1:0] out_class
);

  // Busy after taking a card number
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // No result can appear in the cycle after an accept when no result is pending or the pending one is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
    else $error("result appeared too early");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_class))
    else $error("stalled result changed or dropped");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind card_number_luhn_classifier cnlc_checker u_cnlc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_class (out_chan.card_class)
);

`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for the card number classifier: Luhn check and issuer class.
`timescale 1ns / 100ps

module tb_top;
  import cnlc_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_CARDS = 1250;
  localparam int IDLE_PCT = 32;
  // Window of cycles in which neither side idles
  localparam int CALM_FROM = 20000;
  localparam int CALM_TO = 45000;
  localparam int DRAIN_CYCLES = 120;

  typedef enum {CHECK_RANDOM, CHECK_GOOD, CHECK_BAD} check_digit_t;

  typedef struct {
    logic [CARD_W-1:0]  card;
    logic [CLASS_W-1:0] card_class;
  } class_expectation_t;

  logic clk;
  logic rst_n;

  cnlc_in_if  card_in ();
  cnlc_out_if class_out ();

  card_number_luhn_classifier DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (card_in),
    .out_chan (class_out)
  );

  logic [CARD_W-1:0]  pending_cards[$];
  class_expectation_t expected_classes[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int cycle_no = 0;
  logic card_taken = 1'b0;
  logic calm;

  assign calm = (cycle_no >= CALM_FROM) && (cycle_no < CALM_TO);

  // Count decimal digits of a value
  function automatic int count_digits(longint unsigned v);
    int n = 0;
    while (v != 0) begin
      v = v / 10;
      n++;
    end
    return n;
  endfunction

  // Luhn sum mod 10: double every second digit from the right, fold above 9
  function automatic int luhn_residue(longint unsigned v);
    int pos = 0;
    int sum = 0;
    int d;
    while (v != 0) begin
      d = int'(v % 10);
      if (pos % 2 == 1) begin
        d = 2 * d;
        if (d > 9) d = d - 9;
      end
      sum += d;
      v = v / 10;
      pos++;
    end
    return sum % 10;
  endfunction

  // Issuer class that a card number should get
  function automatic logic [CLASS_W-1:0] predict_card_class(logic [CARD_W-1:0] card);
    longint unsigned v;
    longint unsigned scale;
    int len;
    int lead1;
    int lead2;
    v = {1'b0, card};
    len = count_digits(v);
    if (len != int'(LEN_VISA_SHORT) && len != int'(LEN_AMEX) && len != int'(LEN_LONG))
      return CLASS_INVALID;
    if (luhn_residue(v) != 0) return CLASS_INVALID;
    scale = 1;
    repeat (len - 2) scale = scale * 10;
    lead2 = int'(v / scale);
    lead1 = lead2 / 10;
    if (len == int'(LEN_VISA_SHORT)) begin
      if (lead1 == 4) return CLASS_VISA;
    end else if (len == int'(LEN_AMEX)) begin
      if (lead2 == 34 || lead2 == 37) return CLASS_AMEX;
    end else begin
      if (lead1 == 4) return CLASS_VISA;
      if (lead2 >= 51 && lead2 <= 55) return CLASS_MASTERCARD;
    end
    return CLASS_INVALID;
  endfunction

  // Build a number of len digits starting with prefix; the last digit is random,
  // makes the Luhn sum good, or is one off from good
  function automatic logic [CARD_W-1:0] make_card_number(int len, int prefix,
                                                         check_digit_t mode);
    longint unsigned v;
    int d;
    v = prefix;
    while (count_digits(v) < len - 1) v = v * 10 + $urandom_range(9);
    if (mode == CHECK_RANDOM) begin
      d = $urandom_range(9);
    end else begin
      d = 0;
      while (luhn_residue(v * 10 + d) != 0) d++;
      if (mode == CHECK_BAD) d = (d + 1) % 10;
    end
    v = v * 10 + d;
    return v[CARD_W-1:0];
  endfunction

  function automatic int pick_valid_length();
    case ($urandom_range(2))
      0: return int'(LEN_VISA_SHORT);
      1: return int'(LEN_AMEX);
      default: return int'(LEN_LONG);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive the next card number once the current one is taken; random idles on both sides
  always @(negedge clk) begin
    if (rst_n) begin
      if (!card_in.valid || card_taken) begin
        if (pending_cards.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          card_in.valid <= 1'b1;
          card_in.card_number <= pending_cards.pop_front();
        end else begin
          card_in.valid <= 1'b0;
        end
      end
      class_out.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Predict on each accepted card number, check each accepted class code
  always @(posedge clk) begin
    class_expectation_t head;
    if (!rst_n) begin
      card_taken <= 1'b0;
    end else begin
      card_taken <= card_in.valid && card_in.ready;
      if (card_in.valid && card_in.ready)
        expected_classes.push_back('{card_in.card_number,
                                     predict_card_class(card_in.card_number)});
      if (class_out.valid && class_out.ready) begin
        if (expected_classes.size() == 0) begin
          report_mismatch($sformatf("class %0d with no card outstanding",
                                    class_out.card_class));
        end else begin
          head = expected_classes.pop_front();
          if (class_out.card_class !== head.card_class)
            report_mismatch($sformatf("card %0d: class %0d, want %0d", head.card,
                                      class_out.card_class, head.card_class));
        end
      end
    end
  end

  // Watchdog: abandon the run when no transaction moves for too long
  always @(posedge clk) begin
    cycle_no++;
    if (rst_n) begin
      if ((card_in.valid && card_in.ready) || (class_out.valid && class_out.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d idle cycles", stall_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Stimulus, drain and verdict
  initial begin
    int sel;
    int len;
    logic [63:0] raw;
    rst_n = 1'b0;
    card_in.valid = 1'b0;
    card_in.card_number = '0;
    class_out.ready = 1'b0;

    // Directed: extremes of the field, zero, lengths at and around the valid ones,
    // every issuer, near-miss prefixes and failed checksums
    pending_cards.push_back('0);
    pending_cards.push_back(CARD_W'(1));
    pending_cards.push_back('1);
    pending_cards.push_back(CARD_W'(64'd9999999999999));
    pending_cards.push_back(CARD_W'(64'd1000000000000));
    pending_cards.push_back(CARD_W'(64'd1000000000000000000));
    pending_cards.push_back(make_card_number(13, 4, CHECK_GOOD));
    pending_cards.push_back(make_card_number(13, 5, CHECK_GOOD));
    pending_cards.push_back(make_card_number(13, 4, CHECK_BAD));
    pending_cards.push_back(make_card_number(15, 34, CHECK_GOOD));
    pending_cards.push_back(make_card_number(15, 37, CHECK_GOOD));
    pending_cards.push_back(make_card_number(15, 35, CHECK_GOOD));
    pending_cards.push_back(make_card_number(15, 34, CHECK_BAD));
    pending_cards.push_back(make_card_number(15, 4, CHECK_GOOD));
    pending_cards.push_back(make_card_number(16, 4, CHECK_GOOD));
    pending_cards.push_back(make_card_number(16, 51, CHECK_GOOD));
    pending_cards.push_back(make_card_number(16, 55, CHECK_GOOD));
    pending_cards.push_back(make_card_number(16, 50, CHECK_GOOD));
    pending_cards.push_back(make_card_number(16, 56, CHECK_GOOD));
    pending_cards.push_back(make_card_number(16, 34, CHECK_GOOD));
    pending_cards.push_back(make_card_number(16, 55, CHECK_BAD));
    pending_cards.push_back(make_card_number(14, 4, CHECK_GOOD));
    pending_cards.push_back(make_card_number(12, 4, CHECK_GOOD));
    pending_cards.push_back(make_card_number(17, 51, CHECK_GOOD));

    // Random: mostly well-formed cards, with near misses and noise mixed in
    repeat (RANDOM_CARDS) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        case ($urandom_range(3))
          0: pending_cards.push_back(make_card_number(13, 4, CHECK_GOOD));
          1: pending_cards.push_back(make_card_number(15, $urandom_range(1) ? 37 : 34,
                                                      CHECK_GOOD));
          2: pending_cards.push_back(make_card_number(16, 4, CHECK_GOOD));
          default: pending_cards.push_back(make_card_number(16, $urandom_range(51, 55),
                                                            CHECK_GOOD));
        endcase
      end else if (sel < 75) begin
        len = pick_valid_length();
        pending_cards.push_back(make_card_number(len, $urandom_range(10, 99), CHECK_GOOD));
      end else if (sel < 85) begin
        len = $urandom_range(12, 17);
        pending_cards.push_back(make_card_number(len, $urandom_range(1, 9),
                                                 $urandom_range(1) ? CHECK_BAD : CHECK_GOOD));
      end else if (sel < 90) begin
        raw = {$urandom, $urandom};
        pending_cards.push_back(raw[CARD_W-1:0]);
      end else if (sel < 95) begin
        len = $urandom_range(2, 18);
        pending_cards.push_back(make_card_number(len, $urandom_range(1, 9), CHECK_RANDOM));
      end else begin
        pending_cards.push_back(CARD_W'($urandom_range(9999)));
      end
    end

    // Hold reset, then release on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Wait until every card number is taken and every class code is back
    while (pending_cards.size() != 0 || card_in.valid) @(posedge clk);
    while (expected_classes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_classes.size() != 0)
      report_mismatch($sformatf("%0d class codes never arrived", expected_classes.size()));
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/cnlc_pkg.sv
rtl/cnlc_ifs.sv
rtl/cnlc_b2bcd.sv
rtl/card_number_luhn_classifier.sv
rtl/cnlc_checker.sv
tb/sv/tb_top.sv
